// ===== rtl/wmmf_pkg.sv =====
// package for the 3x3 window mean/median filter
// widths, configuration register codes and defaults; no dependencies
package wmmf_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int PIXEL_BITS   = 8;
   localparam int COL_BITS     = 10;
   localparam int ROW_BITS     = 12;
   localparam int WIDTH_BITS   = 11;
   localparam int HEIGHT_BITS  = 12;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DAT_BITS = 12;
   localparam int WIN_SIZE     = 9;
   localparam int SUM_BITS     = 12;
   localparam int RECIP_BITS   = 13;
   localparam int RECIP_SHIFT  = 16;

   localparam logic [RECIP_BITS-1:0]  MEAN_RECIP     = 13'd7282;
   localparam logic [WIDTH_BITS-1:0]  MIN_WIDTH      = 11'd3;
   localparam logic [WIDTH_BITS-1:0]  MAX_WIDTH_CODE = 11'd1024;
   localparam logic [HEIGHT_BITS-1:0] MIN_HEIGHT     = 12'd3;
   localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH    = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT   = 12'd480;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [COL_BITS-1:0]   col_type;
   typedef logic [ROW_BITS-1:0]   row_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FILTER_MODE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_MEAN   = 1'b0,
      MODE_MEDIAN = 1'b1
   } filter_mode_type;

endpackage

// ===== rtl/wmmf_ifs.sv =====
// valid/ready channel interfaces of the 3x3 window filter
// pixel input, filtered result and register write channels; uses wmmf_pkg
interface wmmf_req_if import wmmf_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

interface wmmf_rsp_if import wmmf_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type filtered_value;
   row_type   centre_row;
   col_type   centre_col;

   modport source (output valid, output filtered_value, output centre_row,
                   output centre_col, input ready);
   modport sink (input valid, input filtered_value, input centre_row,
                 input centre_col, output ready);
endinterface

interface wmmf_csr_if import wmmf_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CSR_DAT_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/window_3x3_mean_median_filter_unit.sv =====
// top level of the 3x3 window mean/median filter
// line memory, window registers, row sort, mean and median stages; uses wmmf_pkg, wmmf_ifs
//
// usage:
//  - req_if carries grey-level pixels in raster order, one transaction per pixel
//  - rsp_if gives one transaction per interior pixel: the mean (sum / 9, truncated)
//    or median of its 3x3 window, with the centre row and column
//  - csr_if writes filter_mode (0), image_width (1), image_height (2); always ready,
//    to be used only while the pipeline is empty; other indexes are ignored
// throughput: one pixel per cycle unless stalled, set by the line memory which is read at
//  acceptance and written back one stage later, both in the same cycle on separate ports
// path: the pixel that completes a window is registered through stage a (memory read), b
//  (window shift), c (row sort) and d (mean/median), whose result register drives rsp_if
// reset: counters, window and pipeline valids clear, registers return to median,
//  640 x 480; the line memory is not cleared, first rows overwrite it
// stall: each stage holds while the next one is full, so req_if keeps accepting
//  until all four stages are full behind a stalled rsp_if
module window_3x3_mean_median_filter_unit
   import wmmf_pkg::*;
(
   input logic clock,
   input logic reset,
   wmmf_req_if.sink   req_if,
   wmmf_rsp_if.source rsp_if,
   wmmf_csr_if.sink   csr_if
);

   function automatic pixel_type pmin(input pixel_type a, input pixel_type b);
      pmin = (a < b) ? a : b;
   endfunction

   function automatic pixel_type pmax(input pixel_type a, input pixel_type b);
      pmax = (a < b) ? b : a;
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      med3 = pmax(pmin(a, b), pmin(pmax(a, b), c));
   endfunction

   // configuration
   filter_mode_type         mode_ff;
   logic [WIDTH_BITS-1:0]   width_ff;
   logic [HEIGHT_BITS-1:0]  height_ff;
   logic [WIDTH_BITS-1:0]   eff_width;
   logic [HEIGHT_BITS-1:0]  eff_height;
   csr_index_type           csr_idx;

   // counters
   col_type                 col_ff;
   row_type                 row_ff;
   logic [WIDTH_BITS-1:0]   col_next;
   logic [HEIGHT_BITS:0]    row_next;

   // stage a: accepted pixel and line memory read data
   logic                    accept;
   logic                    a_vld_ff;
   logic                    a_emit_ff;
   pixel_type               a_pix_ff;
   col_type                 a_col_ff;
   row_type                 a_crow_ff;
   col_type                 a_ccol_ff;
   logic [2*PIXEL_BITS-1:0] rd_ff;
   logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];

   // stage b: window
   logic                    b_vld_ff;
   pixel_type               win_ff [WIN_SIZE];
   row_type                 b_row_ff;
   col_type                 b_col_ff;

   // stage c: sorted rows and sum
   logic                    c_vld_ff;
   pixel_type               srt_ff [WIN_SIZE];
   pixel_type               srt_in [WIN_SIZE];
   logic [SUM_BITS-1:0]     sum_ff;
   logic [SUM_BITS-1:0]     sum_in;
   row_type                 c_row_ff;
   col_type                 c_col_ff;

   // stage d: result register
   logic                    d_vld_ff;
   pixel_type               d_val_ff;
   pixel_type               d_val_in;
   row_type                 d_row_ff;
   col_type                 d_col_ff;
   logic [SUM_BITS+RECIP_BITS-1:0] prod;
   pixel_type               lo_v;
   pixel_type               mi_v;
   pixel_type               hi_v;

   // flow control
   logic                    a_free;
   logic                    b_free;
   logic                    c_free;
   logic                    d_free;
   logic                    a_go;

   assign d_free = !d_vld_ff || rsp_if.ready;
   assign c_free = !c_vld_ff || d_free;
   assign b_free = !b_vld_ff || c_free;
   assign a_free = !a_vld_ff || b_free;
   assign a_go   = a_vld_ff && b_free;
   assign accept = req_if.valid && a_free;

   assign req_if.ready = a_free;
   assign csr_if.ready = 1'b1;
   assign csr_idx      = csr_index_type'(csr_if.index);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_MEDIAN;
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else if (csr_if.valid) begin
         case (csr_idx)
            CSR_FILTER_MODE:  mode_ff   <= filter_mode_type'(csr_if.data[0]);
            CSR_IMAGE_WIDTH:  width_ff  <= csr_if.data[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_if.data[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_width = width_ff;
      if (width_ff < MIN_WIDTH) eff_width = MIN_WIDTH;
      if (width_ff > MAX_WIDTH_CODE) eff_width = MAX_WIDTH_CODE;
      eff_height = (height_ff < MIN_HEIGHT) ? MIN_HEIGHT : height_ff;
      col_next = {1'b0, col_ff} + 1'b1;
      row_next = {1'b0, row_ff} + 1'b1;
   end

   // raster counters advance per accepted pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (col_next >= eff_width) begin
            col_ff <= '0;
            if (row_next >= {1'b0, eff_height}) row_ff <= '0;
            else row_ff <= row_next[ROW_BITS-1:0];
         end else begin
            col_ff <= col_next[COL_BITS-1:0];
         end
      end
   end

   // line memory: entry holds {row r-1, row r-2} of a column
   always_ff @(posedge clock) begin
      if (accept) rd_ff <= line_mem[col_ff];
      if (a_go) line_mem[a_col_ff] <= {a_pix_ff, rd_ff[2*PIXEL_BITS-1:PIXEL_BITS]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_free) begin
         a_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff  <= req_if.pixel_value;
         a_col_ff  <= col_ff;
         a_emit_ff <= (row_ff >= row_type'(2)) && (col_ff >= col_type'(2));
         a_crow_ff <= row_ff - row_type'(1);
         a_ccol_ff <= col_ff - col_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         for (int k = 0; k < WIN_SIZE; k++) win_ff[k] <= '0;
      end else begin
         if (b_free) b_vld_ff <= a_vld_ff && a_emit_ff;
         if (a_go) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[k*3]   <= win_ff[k*3+1];
               win_ff[k*3+1] <= win_ff[k*3+2];
            end
            win_ff[2] <= rd_ff[PIXEL_BITS-1:0];
            win_ff[5] <= rd_ff[2*PIXEL_BITS-1:PIXEL_BITS];
            win_ff[8] <= a_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_go) begin
         b_row_ff <= a_crow_ff;
         b_col_ff <= a_ccol_ff;
      end
   end

   // sort each window row, sum all nine
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < 3; k++) begin
         srt_in[k*3]   = pmin(pmin(win_ff[k*3], win_ff[k*3+1]), win_ff[k*3+2]);
         srt_in[k*3+1] = med3(win_ff[k*3], win_ff[k*3+1], win_ff[k*3+2]);
         srt_in[k*3+2] = pmax(pmax(win_ff[k*3], win_ff[k*3+1]), win_ff[k*3+2]);
      end
      for (int k = 0; k < WIN_SIZE; k++) begin
         sum_in = sum_in + SUM_BITS'(win_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (c_free) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_free && b_vld_ff) begin
         srt_ff   <= srt_in;
         sum_ff   <= sum_in;
         c_row_ff <= b_row_ff;
         c_col_ff <= b_col_ff;
      end
   end

   // median of nine from sorted rows; mean by reciprocal multiply
   always_comb begin
      lo_v = pmax(pmax(srt_ff[0], srt_ff[3]), srt_ff[6]);
      mi_v = med3(srt_ff[1], srt_ff[4], srt_ff[7]);
      hi_v = pmin(pmin(srt_ff[2], srt_ff[5]), srt_ff[8]);
      prod = {{RECIP_BITS{1'b0}}, sum_ff} * {{SUM_BITS{1'b0}}, MEAN_RECIP};
      if (mode_ff == MODE_MEDIAN) d_val_in = med3(lo_v, mi_v, hi_v);
      else d_val_in = prod[RECIP_SHIFT +: PIXEL_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (d_free) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (d_free && c_vld_ff) begin
         d_val_ff <= d_val_in;
         d_row_ff <= c_row_ff;
         d_col_ff <= c_col_ff;
      end
   end

   assign rsp_if.valid          = d_vld_ff;
   assign rsp_if.filtered_value = d_val_ff;
   assign rsp_if.centre_row     = d_row_ff;
   assign rsp_if.centre_col     = d_col_ff;

   // interior pixels only
   a_interior: assert property (@(posedge clock) disable iff (reset)
      d_vld_ff |-> (d_row_ff != '0) && (d_col_ff != '0))
      else $error("result for a border pixel");

   // window must not shift under a held result
   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      a_go |-> (!b_vld_ff || c_free))
      else $error("window shifted while its result was held");

   // input stalls only when every stage is full behind a stalled output
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> a_vld_ff && b_vld_ff && c_vld_ff && d_vld_ff && !rsp_if.ready)
      else $error("input stalled with room in the pipeline");

   // the sort stage loads only after an interior pixel passed the window stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(c_vld_ff) |-> $past(b_vld_ff))
      else $error("sort stage loaded without a window");

endmodule

// ===== tb/sv/wmmf_filter_checker.sv =====
// result checker for the 3x3 window mean/median filter
// tracks registers and pixel transactions, predicts each filtered pixel, compares results
// depends on wmmf_pkg and the wmmf channel interfaces
module wmmf_filter_checker
   import wmmf_pkg::*;
(
   input  logic clock,
   input  logic reset,
   wmmf_req_if  req_if,
   wmmf_rsp_if  rsp_if,
   wmmf_csr_if  csr_if,
   output int   mismatch_count,
   output int   pixels_seen,
   output int   results_seen,
   output int   results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 100;

   typedef struct packed {
      pixel_type value;
      row_type   row;
      col_type   col;
   } filtered_pixel_type;

   filtered_pixel_type     expected_pixels[$];
   filter_mode_type        mode;
   logic [WIDTH_BITS-1:0]  width_code;
   logic [HEIGHT_BITS-1:0] height_code;
   pixel_type              row_above[MAX_WIDTH];
   pixel_type              row_above2[MAX_WIDTH];
   pixel_type              window[WIN_SIZE];
   int unsigned            col_pos;
   int unsigned            row_pos;
   int                     mismatches;
   int                     pixel_total;
   int                     result_total;

   initial begin
      mismatches   = 0;
      pixel_total  = 0;
      result_total = 0;
      foreach (row_above[k]) begin
         row_above[k]  = '0;
         row_above2[k] = '0;
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP) begin
         $display("[%0t ns] filter mismatch: %s", $realtime, what);
      end
      mismatches++;
   endtask

   function automatic pixel_type window_mean();
      int unsigned sum;
      sum = 0;
      foreach (window[k]) sum += window[k];
      return pixel_type'(sum / WIN_SIZE);
   endfunction

   function automatic pixel_type window_median();
      pixel_type sorted[WIN_SIZE];
      pixel_type key;
      int        j;
      sorted = window;
      for (int i = 1; i < WIN_SIZE; i++) begin
         key = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > key) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = key;
      end
      return sorted[WIN_SIZE / 2];
   endfunction

   function automatic void filter_pixel(input pixel_type px);
      pixel_type   above1;
      pixel_type   above2;
      int unsigned row_len;
      int unsigned frame_len;
      above1 = row_above[col_pos];
      above2 = row_above2[col_pos];
      for (int k = 0; k < 3; k++) begin
         window[k * 3]     = window[k * 3 + 1];
         window[k * 3 + 1] = window[k * 3 + 2];
      end
      window[2] = above2;
      window[5] = above1;
      window[8] = px;
      row_above2[col_pos] = above1;
      row_above[col_pos]  = px;
      if (row_pos >= 2 && col_pos >= 2) begin
         expected_pixels.push_back('{
            value: (mode == MODE_MEDIAN) ? window_median() : window_mean(),
            row:   row_type'(row_pos - 1),
            col:   col_type'(col_pos - 1)});
      end
      row_len = width_code;
      if (width_code < MIN_WIDTH) row_len = MIN_WIDTH;
      if (width_code > MAX_WIDTH_CODE) row_len = MAX_WIDTH_CODE;
      frame_len = (height_code < MIN_HEIGHT) ? MIN_HEIGHT : height_code;
      if (col_pos + 1 >= row_len) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= frame_len) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endfunction

   always @(posedge clock) begin
      filtered_pixel_type got;
      filtered_pixel_type want;
      if (reset) begin
         mode        = MODE_MEDIAN;
         width_code  = RESET_WIDTH;
         height_code = RESET_HEIGHT;
         foreach (window[k]) window[k] = '0;
         col_pos = 0;
         row_pos = 0;
         expected_pixels.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_FILTER_MODE:  mode = filter_mode_type'(csr_if.data[0]);
               CSR_IMAGE_WIDTH:  width_code = csr_if.data[WIDTH_BITS-1:0];
               CSR_IMAGE_HEIGHT: height_code = csr_if.data[HEIGHT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            filter_pixel(req_if.pixel_value);
            pixel_total++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            result_total++;
            got = '{rsp_if.filtered_value, rsp_if.centre_row, rsp_if.centre_col};
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected result %0d at row %0d col %0d",
                  got.value, got.row, got.col));
            end else begin
               want = expected_pixels.pop_front();
               if (got.row !== want.row) begin
                  report_mismatch($sformatf("centre_row %0d, predicted %0d",
                     got.row, want.row));
               end
               if (got.col !== want.col) begin
                  report_mismatch($sformatf("centre_col %0d, predicted %0d",
                     got.col, want.col));
               end
               if (got.value !== want.value) begin
                  report_mismatch($sformatf("filtered_value %0d, predicted %0d at row %0d col %0d",
                     got.value, want.value, want.row, want.col));
               end
            end
         end
      end
      mismatch_count  <= mismatches;
      pixels_seen     <= pixel_total;
      results_seen    <= result_total;
      results_pending <= expected_pixels.size();
   end

endmodule

// ===== tb/sv/tb_window_3x3_mean_median_filter_unit.sv =====
// testbench top for window_3x3_mean_median_filter_unit
// streams pixel frames under bursty flow control and varied geometry, gives the verdict
// depends on wmmf_pkg, the wmmf channel interfaces, the filter rtl and wmmf_filter_checker
module tb_window_3x3_mean_median_filter_unit
   import wmmf_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 12;
   localparam int DRAIN_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RANDOM_PIXELS = 1300;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam pixel_type MEDIAN_PROBE [WIN_SIZE] =
      '{8'd255, 8'd0, 8'd200, 8'd17, 8'd128, 8'd1, 8'd254, 8'd90, 8'd129};

   typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_CLUSTER} pixel_style_type;

   logic clock;
   logic reset;

   wmmf_req_if req_if();
   wmmf_rsp_if rsp_if();
   wmmf_csr_if csr_if();

   int mismatch_count;
   int pixels_seen;
   int results_seen;
   int results_pending;

   int unsigned     sent_pixels = 0;
   int unsigned     register_writes = 0;
   int unsigned     burst_left = 0;
   int unsigned     stream_col = 0;
   int unsigned     stream_row = 0;
   int unsigned     frame_cols = RESET_WIDTH;
   int unsigned     frame_rows = RESET_HEIGHT;
   filter_mode_type current_mode = MODE_MEDIAN;

   window_3x3_mean_median_filter_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   wmmf_filter_checker filter_check (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .csr_if          (csr_if),
      .mismatch_count  (mismatch_count),
      .pixels_seen     (pixels_seen),
      .results_seen    (results_seen),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
         results_pending);
      $display("** window_3x3_mean_median_filter_unit: FAILED **");
      $finish;
   end

   // result side stalls on its own pattern, with long stretches of no stall
   initial begin
      int unsigned span;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         span = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
         rsp_if.ready <= 1'b1;
         repeat (span) @(posedge clock);
         span = $urandom_range(0, 6);
         if (span != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end
      end
   end

   function automatic pixel_type make_pixel(input pixel_style_type style,
                                            input pixel_type centre);
      case (style)
         PIX_EXTREME: return $urandom_range(0, 1) ? pixel_type'('1) : pixel_type'('0);
         PIX_CLUSTER: return pixel_type'(int'(centre) + $urandom_range(0, 4) - 2);
         default:     return pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input pixel_type value);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1, 2:    gap = $urandom_range(1, 4);
            default: gap = $urandom_range(5, 20);
         endcase
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.pixel_value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_pixels++;
      if (stream_col + 1 >= frame_cols) begin
         stream_col = 0;
         stream_row = (stream_row + 1 >= frame_rows) ? 0 : stream_row + 1;
      end else begin
         stream_col++;
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pixels_seen != sent_pixels || results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves valid high so that writes can follow back to back
   task automatic write_register(input logic [CSR_IDX_BITS-1:0] index,
                                 input logic [CSR_DAT_BITS-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      register_writes++;
      case (index)
         CSR_FILTER_MODE: current_mode = filter_mode_type'(data[0]);
         CSR_IMAGE_WIDTH: begin
            frame_cols = data[WIDTH_BITS-1:0];
            if (data[WIDTH_BITS-1:0] < MIN_WIDTH) frame_cols = MIN_WIDTH;
            if (data[WIDTH_BITS-1:0] > MAX_WIDTH_CODE) frame_cols = MAX_WIDTH_CODE;
         end
         CSR_IMAGE_HEIGHT: frame_rows = (data < MIN_HEIGHT) ? MIN_HEIGHT : data;
         default: ;
      endcase
   endtask

   task automatic update_register(input logic [CSR_IDX_BITS-1:0] index,
                                  input logic [CSR_DAT_BITS-1:0] data);
      wait_idle();
      write_register(index, data);
      csr_if.valid <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DAT_BITS-1:0] mode_data,
                            input logic [CSR_DAT_BITS-1:0] width_data,
                            input logic [CSR_DAT_BITS-1:0] height_data,
                            input bit poke_spare);
      wait_idle();
      write_register(CSR_FILTER_MODE, mode_data);
      write_register(CSR_IMAGE_WIDTH, width_data);
      write_register(CSR_IMAGE_HEIGHT, height_data);
      if (poke_spare) write_register(CSR_SPARE_INDEX, '1);
      csr_if.valid <= 1'b0;
   endtask

   // a width shrink only comes once two full rows of this frame are in the line store
   task automatic send_frame(input pixel_style_type style, input pixel_type centre,
                             input int twist_at);
      int pos;
      pos = 0;
      do begin
         if (pos == twist_at) begin
            case ($urandom_range(0, 2))
               0: update_register(CSR_FILTER_MODE, CSR_DAT_BITS'(
                     (current_mode == MODE_MEAN) ? MODE_MEDIAN : MODE_MEAN));
               1: update_register(CSR_IMAGE_WIDTH,
                     CSR_DAT_BITS'($urandom_range(MIN_WIDTH, frame_cols)));
               default: update_register(CSR_IMAGE_HEIGHT,
                     CSR_DAT_BITS'($urandom_range(0, frame_rows + 3)));
            endcase
         end
         send_pixel(make_pixel(style, centre));
         pos++;
      end while (stream_col != 0 || stream_row != 0);
   endtask

   initial begin
      int unsigned                random_start;
      int unsigned                frames;
      int                         twist_at;
      logic [CSR_DAT_BITS-1:0]    width_data;
      logic [CSR_DAT_BITS-1:0]    height_data;
      pixel_style_type            style;
      pixel_type                  centre;

      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.pixel_value <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= CSR_FILTER_MODE;
      csr_if.data        <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // full-scale mean, then median on a clamped 3x3 geometry with an unused index write
      configure({{(CSR_DAT_BITS-1){1'b1}}, MODE_MEAN}, CSR_DAT_BITS'(MIN_WIDTH),
         CSR_DAT_BITS'(MIN_HEIGHT), 1'b0);
      repeat (WIN_SIZE) send_pixel('1);
      configure(CSR_DAT_BITS'(MODE_MEDIAN), 12'd0, 12'd1, 1'b1);
      for (int k = 0; k < WIN_SIZE; k++) send_pixel(MEDIAN_PROBE[k]);

      random_start = sent_pixels;
      while (sent_pixels - random_start < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0:       width_data = CSR_DAT_BITS'($urandom_range(0, 2));
            1, 2:    width_data = CSR_DAT_BITS'($urandom_range(17, 64));
            default: width_data = CSR_DAT_BITS'($urandom_range(3, 16));
         endcase
         height_data = ($urandom_range(0, 4) == 0) ? CSR_DAT_BITS'($urandom_range(0, 2))
                                                   : CSR_DAT_BITS'($urandom_range(3, 8));
         style  = pixel_style_type'($urandom_range(0, 2));
         centre = pixel_type'($urandom_range(0, 255));
         configure(CSR_DAT_BITS'($urandom_range(0, 1)), width_data, height_data, 1'b0);
         frames = $urandom_range(1, 2);
         twist_at = ($urandom_range(0, 2) == 0)
            ? $urandom_range(2 * frame_cols, frame_cols * frame_rows - 1) : -1;
         for (int f = 0; f < frames; f++) begin
            send_frame(style, centre, (f == 0) ? twist_at : -1);
         end
      end

      wait_idle();
      $display("run covered %0d pixels and %0d filtered results after %0d register writes",
         sent_pixels, results_seen, register_writes);
      $display("frames from 3x3 up to 64 columns, clamped codes, mid-frame changes, both modes");
      if (mismatch_count == 0) begin
         $display("** window_3x3_mean_median_filter_unit: PASSED **");
      end else begin
         $display("** window_3x3_mean_median_filter_unit: FAILED **");
      end
      $finish;
   end

endmodule
